// ----- sv/bfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants for the shortest path engine
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam logic signed [31:0] DIST_INF = 32'sh7FFF_FFFF;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_RELAX = 7'b0001000,
    ST_PEND  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

  // matrix port request from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } mat_req_t;

endpackage

// ----- sv/bfsp_matrix.sv -----
// ----------------------------------------------------------------------------
// bfsp_matrix
// Adjacency weight memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfsp_matrix #(
  parameter int AW = 10,
  parameter int WB = 16
) (
  input  logic                 clk,
  input  bfsp_pkg::mat_req_t   req,
  input  logic [AW-1:0]        waddr,
  input  logic signed [WB-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [WB-1:0] rdata
);

  logic signed [WB-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= wdata;
    end
    if (req.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bfsp_dist.sv -----
// ----------------------------------------------------------------------------
// bfsp_dist
// Distance, reached and parent store with a registered read port
// ----------------------------------------------------------------------------
module bfsp_dist #(
  parameter int VB = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [VB-1:0]     waddr,
  input  logic signed [31:0] wdist,
  input  logic              wreach,
  input  logic              whas,
  input  logic [VB-1:0]     wpar,
  input  logic [VB-1:0]     raddr,
  output logic signed [31:0] rdist,
  output logic              rreach,
  output logic              rhas,
  output logic [VB-1:0]     rpar
);

  logic [VB+33:0] mem [2**VB];
  logic [VB+33:0] q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdist, wreach, whas, wpar};
    end
    q <= mem[raddr];
  end

  assign rdist  = q[VB+33:VB+2];
  assign rreach = q[VB+1];
  assign rhas   = q[VB];
  assign rpar   = q[VB-1:0];

endmodule

// ----- sv/bellman_ford_shortest_paths.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Single-source shortest paths over a dense weight matrix
// ----------------------------------------------------------------------------
// Input items with mode 0 write one weight into the matrix and give no
// result. An item with mode 1 runs the search from the configured source
// over the configured vertex count and gives one result item per vertex,
// in order, with last on the final one. Both channels use valid/stall; the
// result waits in an output register while stall is high and the sequencer
// holds. A run first initialises all V vertices; then each pass reads the
// distance of each row u and, for a reached row, the weight and distance of
// each v, then compares and writes back, and ends with a pass-end step, for
// up to V passes including the check pass; then the results follow, one per
// vertex, held while the receiver stalls. The single read port of the
// distance store sets the pace. After reset a clearing pass zeroes all
// 2**(2*VB) matrix entries, during which no item is taken; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [4:0]         from_vertex,
  input  logic [4:0]         to_vertex,
  input  logic signed [15:0] edge_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         vertex,
  output logic signed [31:0] distance,
  output logic               reachable,
  output logic [4:0]         parent,
  output logic               has_parent,
  output logic               negative_cycle,
  output logic               last
);

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VB;
  localparam int CB = VB + 1;

  bfsp_pkg::state_t state;
  logic [5:0]  vcount;
  logic [4:0]  src;
  logic [CB-1:0] n, u, v, pass;
  logic [AW:0] clr;
  logic        changed, check, neg, phase;
  logic signed [31:0] du;

  bfsp_pkg::mat_req_t mreq;
  logic [AW-1:0] maddr_w, maddr_r;
  logic signed [WEIGHT_BITS-1:0] mwdata, w;

  logic dwe, dwreach, dwhas;
  logic [VB-1:0] dwaddr, dwpar, draddr, drpar;
  logic signed [31:0] dwdist, drdist;
  logic drreach, drhas;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= 6'd32;
      src    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) begin
        vcount <= cfg_data[5:0];
      end else begin
        src <= cfg_data[4:0];
      end
    end
  end

  logic [CB-1:0] n_next;
  always_comb begin
    if (vcount == 6'd0) begin
      n_next = CB'(1);
    end else if ({26'd0, vcount} > 32'(MAX_VERTICES)) begin
      n_next = CB'(MAX_VERTICES);
    end else begin
      n_next = CB'(vcount);
    end
  end

  logic accept;
  assign in_stall = (state != bfsp_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  logic ld_ok;
  assign ld_ok = ({27'd0, from_vertex} < 32'(MAX_VERTICES)) &&
                 ({27'd0, to_vertex} < 32'(MAX_VERTICES));

  always_comb begin
    mreq.we = 1'b0;
    maddr_w = {VB'(from_vertex), VB'(to_vertex)};
    mwdata  = WEIGHT_BITS'(edge_weight);
    if (state == bfsp_pkg::ST_CLEAR) begin
      mreq.we = 1'b1;
      maddr_w = clr[AW-1:0];
      mwdata  = '0;
    end else if (accept && !mode && ld_ok) begin
      mreq.we = 1'b1;
    end
    mreq.re = (state == bfsp_pkg::ST_RD);
    maddr_r = {u[VB-1:0], v[VB-1:0]};
  end

  bfsp_matrix #(.AW(AW), .WB(WEIGHT_BITS)) u_matrix (
    .clk(clk), .req(mreq), .waddr(maddr_w), .wdata(mwdata),
    .raddr(maddr_r), .rdata(w)
  );

  bfsp_dist #(.VB(VB)) u_dist (
    .clk(clk), .we(dwe), .waddr(dwaddr), .wdist(dwdist), .wreach(dwreach),
    .whas(dwhas), .wpar(dwpar), .raddr(draddr), .rdist(drdist),
    .rreach(drreach), .rhas(drhas), .rpar(drpar)
  );

  // candidate from the reached source row
  logic signed [33:0] sum;
  logic signed [31:0] cand;
  logic urch, relax;
  assign sum = 34'(du) + 34'(w);
  always_comb begin
    if (sum > 34'sh0_7FFF_FFFF) begin
      cand = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      cand = 32'sh8000_0000;
    end else begin
      cand = sum[31:0];
    end
  end
  assign relax = urch && (w != '0) && (!drreach || drdist > cand);

  logic out_free, emit_load;
  assign out_free  = !out_valid || !out_stall;
  assign emit_load = (state == bfsp_pkg::ST_EMIT) && phase && out_free;

  always_comb begin
    dwe     = 1'b0;
    dwaddr  = v[VB-1:0];
    dwdist  = cand;
    dwreach = 1'b1;
    dwhas   = 1'b1;
    dwpar   = u[VB-1:0];
    draddr  = v[VB-1:0];
    if (state == bfsp_pkg::ST_INIT) begin
      dwe     = 1'b1;
      dwdist  = '0;
      dwreach = (32'(v) == 32'(src));
      dwhas   = 1'b0;
      dwpar   = '0;
    end else if (state == bfsp_pkg::ST_RELAX && phase && relax && !check) begin
      dwe = 1'b1;
    end
    if (state == bfsp_pkg::ST_RD && !phase) begin
      draddr = u[VB-1:0];
    end
  end

  logic [CB-1:0] v1, u1;
  assign v1 = v + CB'(1);
  assign u1 = u + CB'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfsp_pkg::ST_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      phase     <= 1'b0;
      check     <= 1'b0;
      changed   <= 1'b0;
      neg       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bfsp_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(2**AW - 1)) begin
            state <= bfsp_pkg::ST_IDLE;
          end
        end
        bfsp_pkg::ST_IDLE: begin
          if (accept && mode) begin
            n     <= n_next;
            v     <= '0;
            state <= bfsp_pkg::ST_INIT;
          end
        end
        bfsp_pkg::ST_INIT: begin
          v <= v1;
          if (v1 == n) begin
            neg   <= 1'b0;
            v     <= '0;
            if (32'(src) >= 32'(n)) begin
              state <= bfsp_pkg::ST_EMIT;
            end else begin
              u       <= '0;
              pass    <= '0;
              changed <= 1'b0;
              check   <= (n == CB'(1));
              phase   <= 1'b0;
              state   <= bfsp_pkg::ST_RD;
            end
          end
        end
        // phase 0 reads dist[u], phase 1 reads w[u][v] and dist[v]
        bfsp_pkg::ST_RD: begin
          state <= bfsp_pkg::ST_RELAX;
        end
        bfsp_pkg::ST_RELAX: begin
          if (!phase) begin
            du    <= drdist;
            urch  <= drreach;
            phase <= 1'b1;
            if (!drreach) begin
              // skip the row
              phase <= 1'b0;
              v     <= '0;
              if (u1 == n) begin
                state <= bfsp_pkg::ST_PEND;
              end else begin
                u     <= u1;
                state <= bfsp_pkg::ST_RD;
              end
            end else begin
              state <= bfsp_pkg::ST_RD;
            end
          end else begin
            if (relax) begin
              changed <= 1'b1;
            end
            // a self loop lowers the row's own distance for the rest of the row
            if (relax && !check && v == u) begin
              du <= cand;
            end
            if (relax && check) begin
              neg   <= 1'b1;
              v     <= '0;
              phase <= 1'b0;
              state <= bfsp_pkg::ST_EMIT;
            end else if (v1 == n) begin
              v     <= '0;
              phase <= 1'b0;
              if (u1 == n) begin
                state <= bfsp_pkg::ST_PEND;
              end else begin
                u     <= u1;
                state <= bfsp_pkg::ST_RD;
              end
            end else begin
              v     <= v1;
              state <= bfsp_pkg::ST_RD;
            end
          end
        end
        // end of a pass
        bfsp_pkg::ST_PEND: begin
          u       <= '0;
          changed <= 1'b0;
          phase   <= 1'b0;
          if (check) begin
            v     <= '0;
            state <= bfsp_pkg::ST_EMIT;
          end else if (!changed || pass + CB'(2) >= n) begin
            check <= 1'b1;
            state <= bfsp_pkg::ST_RD;
          end else begin
            pass  <= pass + CB'(1);
            state <= bfsp_pkg::ST_RD;
          end
        end
        // phase 0 waits on the read, phase 1 loads the output
        bfsp_pkg::ST_EMIT: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            vertex         <= 5'(v);
            reachable      <= drreach;
            distance       <= drreach ? drdist : bfsp_pkg::DIST_INF;
            has_parent     <= drreach && drhas;
            parent         <= (drreach && drhas) ? 5'(drpar) : 5'd0;
            negative_cycle <= neg;
            last           <= (v1 == n);
            phase          <= 1'b0;
            v              <= v1;
            if (v1 == n) begin
              state <= bfsp_pkg::ST_IDLE;
            end
          end
        end
        default: state <= bfsp_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bfsp_checker.sv -----
// ----------------------------------------------------------------------------
// bfsp_checker
// Port level checks for the shortest path engine
// ----------------------------------------------------------------------------
module bfsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] vertex,
  input logic       last,
  input logic       negative_cycle
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex))
    else $error("result dropped under stall");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("item taken during a run");

  a_order: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_stall && !last) && out_valid |->
      vertex == $past(vertex) + 5'd1)
    else $error("vertex out of order");

  a_neg: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_stall && !last) && out_valid |->
      negative_cycle == $past(negative_cycle))
    else $error("cycle flag changed within a run");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .vertex(vertex),
  .last(last), .negative_cycle(negative_cycle)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Bellman-Ford shortest path engine
// ----------------------------------------------------------------------------
// Loads small weighted graphs into the matrix and starts runs. A model of the
// search inside the bench gives the expected per-vertex items. The checker
// compares each result item with the oldest one expected. Both channels idle
// at random, with one long hold-off on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NV = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_SOURCE = 1'b1;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef struct packed {
    logic [4:0]         vertex;
    logic signed [31:0] distance;
    logic               reachable;
    logic [4:0]         parent;
    logic               has_parent;
    logic               negative_cycle;
    logic               last;
  } path_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [4:0]         from_vertex = '0;
  logic [4:0]         to_vertex = '0;
  logic signed [15:0] edge_weight = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         vertex;
  logic signed [31:0] distance;
  logic               reachable;
  logic [4:0]         parent;
  logic               has_parent;
  logic               negative_cycle;
  logic               last;

  bellman_ford_shortest_paths i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the engine state
  logic signed [15:0] graph_w [NV*NV];
  logic [5:0]         vcount_reg;
  logic [4:0]         source_reg;
  logic signed [31:0] dist_m [NV];
  logic               seen_m [NV];
  logic               hasp_m [NV];
  logic [4:0]         par_m [NV];

  path_item_t paths_due[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int stall_mode = 0;

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a,
                                                 logic signed [15:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -34'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic relax_sweep(int n, logic upd);
    logic ch;
    logic signed [31:0] cand;
    ch = 1'b0;
    for (int u = 0; u < n; u++)
      for (int v = 0; v < n; v++) begin
        if (graph_w[u*NV+v] != 0 && seen_m[u]) begin
          cand = add_sat(dist_m[u], graph_w[u*NV+v]);
          if (!seen_m[v] || dist_m[v] > cand) begin
            ch = 1'b1;
            if (!upd) return 1'b1;
            dist_m[v] = cand;
            seen_m[v] = 1'b1;
            hasp_m[v] = 1'b1;
            par_m[v] = 5'(u);
          end
        end
      end
    return ch;
  endfunction

  task automatic predict_paths();
    int n;
    logic neg;
    path_item_t r;
    n = vcount_reg;
    if (n < 1) n = 1;
    if (n > NV) n = NV;
    neg = 1'b0;
    for (int i = 0; i < n; i++) begin
      dist_m[i] = 0; seen_m[i] = 0; hasp_m[i] = 0; par_m[i] = 0;
    end
    if (source_reg < n) begin
      seen_m[source_reg] = 1'b1;
      for (int p = 0; p + 1 < n; p++)
        if (!relax_sweep(n, 1'b1)) break;
      neg = relax_sweep(n, 1'b0);
    end
    for (int i = 0; i < n; i++) begin
      r.vertex = 5'(i);
      r.distance = seen_m[i] ? dist_m[i] : bfsp_pkg::DIST_INF;
      r.reachable = seen_m[i];
      r.parent = hasp_m[i] ? par_m[i] : 5'd0;
      r.has_parent = hasp_m[i];
      r.negative_cycle = neg;
      r.last = (i + 1 == n);
      paths_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    path_item_t w;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (paths_due.size() == 0) begin
        report_mismatch("unexpected item, vertex", vertex, -1);
      end else begin
        w = paths_due.pop_front();
        if (vertex !== w.vertex) report_mismatch("vertex", vertex, w.vertex);
        if (distance !== w.distance) report_mismatch("distance", distance, w.distance);
        if (reachable !== w.reachable) report_mismatch("reachable", reachable, w.reachable);
        if (parent !== w.parent) report_mismatch("parent", parent, w.parent);
        if (has_parent !== w.has_parent)
          report_mismatch("has_parent", has_parent, w.has_parent);
        if (negative_cycle !== w.negative_cycle)
          report_mismatch("negative_cycle", negative_cycle, w.negative_cycle);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_VCOUNT) vcount_reg = val[5:0];
    else source_reg = val[4:0];
  endtask

  // one input item; valid stays high into the next call when no gap is taken
  task automatic send_item(logic m, logic [4:0] f, logic [4:0] t,
                           logic signed [15:0] wt, int gap);
    in_valid <= 1'b1;
    mode <= m;
    from_vertex <= f;
    to_vertex <= t;
    edge_weight <= wt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_LOAD) graph_w[{f, t}] = wt;
    else predict_paths();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (paths_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic clear_graph(int n);
    for (int u = 0; u < n; u++)
      for (int v = 0; v < n; v++)
        if (graph_w[u*NV+v] != 0) send_item(MODE_LOAD, 5'(u), 5'(v), 16'sd0, 0);
  endtask

  task automatic test_directed();
    write_reg(CFG_VCOUNT, 32'd4);
    write_reg(CFG_SOURCE, 32'd0);
    send_item(MODE_LOAD, 5'd0, 5'd1, 16'sd5, 0);
    send_item(MODE_LOAD, 5'd1, 5'd2, -16'sd3, 1);
    send_item(MODE_LOAD, 5'd0, 5'd2, 16'sd7, 0);
    send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
    // extremes of the weight with saturation
    send_item(MODE_LOAD, 5'd2, 5'd3, 16'sh8000, 0);
    send_item(MODE_LOAD, 5'd31, 5'd31, 16'sh7FFF, 0);
    send_item(MODE_RUN, 5'd31, 5'd31, -16'sd1, 2);
    drain();
    // negative cycle
    send_item(MODE_LOAD, 5'd3, 5'd1, 16'sd2, 0);
    send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
    drain();
    // source not below vertex count, then zero vertex count
    write_reg(CFG_SOURCE, 32'd31);
    send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
    drain();
    write_reg(CFG_VCOUNT, 32'd0);
    write_reg(CFG_SOURCE, 32'd0);
    send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
    drain();
    write_reg(CFG_VCOUNT, 32'd63);
    send_item(MODE_LOAD, 5'd3, 5'd1, 16'sd0, 0);
    send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
    drain();
    clear_graph(NV);
    drain();
  endtask

  task automatic test_random_graphs();
    int n, edges;
    stall_mode = 1;
    for (int g = 0; g < 6; g++) begin
      n = (g == 5) ? 32 : $urandom_range(2, 8);
      write_reg(CFG_VCOUNT, 32'(n));
      write_reg(CFG_SOURCE, 32'($urandom_range(0, n - 1)));
      edges = $urandom_range(3, 10);
      for (int e = 0; e < edges; e++)
        send_item(MODE_LOAD, ($urandom_range(0, 3) == 0) ? 5'($urandom) :
                  5'($urandom_range(0, n - 1)), 5'($urandom_range(0, n - 1)),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'($signed($urandom_range(0, 40)) - 8),
                  ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
      send_item(MODE_RUN, 5'($urandom), 5'($urandom), 16'($urandom), 0);
      // second run queued behind the first, with results held off in one graph
      if (g == 3) hold_cycles = 3000;
      send_item(MODE_RUN, 5'd0, 5'd0, 16'sd0, 0);
      drain();
      clear_graph(NV);
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NV*NV; i++) graph_w[i] = 0;
    vcount_reg = 6'd32;
    source_reg = 5'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_graphs();
    drain();
    if (errors == 0 && paths_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bfsp_pkg.sv
sv/bfsp_matrix.sv
sv/bfsp_dist.sv
sv/bellman_ford_shortest_paths.sv
sv/bfsp_checker.sv
verif/tb_top.sv
